// File: rtl/tws_pkg.sv
// Shared types, word constants and lookup functions for the two-word stream replacer.
`timescale 1ns / 1ps
`default_nettype none

package tws_pkg;

    localparam int BYTE_W    = 8;
    localparam int SEQ_CNT_W = 4;

    localparam int PAT1_LEN = 3;
    localparam int REP1_LEN = 9;
    localparam int PAT2_LEN = 5;
    localparam int REP2_LEN = 6;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // One byte of a stream together with its end-of-stream mark.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } tws_item_t;

    typedef enum logic [1:0] {
        TAIL_NONE = 2'd0,
        TAIL_BYTE = 2'd1,
        TAIL_REP  = 2'd2
    } tws_tail_t;

    // What a matcher must emit for one incoming byte: a prefix of its pattern,
    // then either nothing, the incoming byte, or the whole replacement word.
    typedef struct packed {
        logic [SEQ_CNT_W-1:0] pre_len;
        tws_tail_t            tail;
        logic [BYTE_W-1:0]    data;
        logic                 last;
    } tws_seq_t;

    function automatic logic [SEQ_CNT_W-1:0] seq_len(input tws_seq_t s,
                                                     input logic [SEQ_CNT_W-1:0] rep_len);
        logic [SEQ_CNT_W-1:0] n;
        case (s.tail)
            TAIL_BYTE: n = s.pre_len + SEQ_CNT_W'(1);
            TAIL_REP:  n = s.pre_len + rep_len;
            default:   n = s.pre_len;
        endcase
        return n;
    endfunction

    function automatic logic [BYTE_W-1:0] pat1_byte(input logic [1:0] i);
        logic [BYTE_W-1:0] b;
        case (i)
            2'd0:    b = "x";
            2'd1:    b = "u";
            default: b = "n";
        endcase
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] rep1_byte(input logic [SEQ_CNT_W-1:0] i);
        logic [BYTE_W-1:0] b;
        case (i)
            4'd0:    b = "w";
            4'd1:    b = "a";
            4'd2:    b = "n";
            4'd3:    b = "a";
            4'd4:    b = "a";
            4'd5:    b = "g";
            4'd6:    b = "s";
            4'd7:    b = "a";
            default: b = "n";
        endcase
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] pat2_byte(input logic [2:0] i);
        logic [BYTE_W-1:0] b;
        case (i)
            3'd0:    b = "n";
            3'd1:    b = "a";
            3'd2:    b = "c";
            3'd3:    b = "a";
            default: b = "s";
        endcase
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] rep2_byte(input logic [2:0] i);
        logic [BYTE_W-1:0] b;
        case (i)
            3'd0:    b = "f";
            3'd1:    b = "a";
            3'd2:    b = "r";
            3'd3:    b = "i";
            3'd4:    b = "i";
            default: b = "d";
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// File: rtl/tws_front.sv
// Front matcher: accepts input transfers, rewrites the first "xun" and feeds the queue.
`timescale 1ns / 1ps
`default_nettype none

module tws_front import tws_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [BYTE_W-1:0] s_tdata,
    input  wire logic              s_tlast,
    output tws_item_t              push_item,
    output logic                   push_valid,
    input  wire logic              push_ready
);

    logic [1:0]           prog_reg, prog_next;
    logic                 done_reg, done_next;
    logic                 busy_reg;
    logic [SEQ_CNT_W-1:0] idx_reg;
    logic [SEQ_CNT_W-1:0] len_reg;
    tws_seq_t             seq_reg;
    tws_seq_t             seq_in;
    logic [SEQ_CNT_W-1:0] len_in;
    logic                 accept;
    logic                 final_idx;
    logic                 last_beat;
    logic [BYTE_W-1:0]    emit_byte;

    always_comb begin
        seq_in.data    = s_tdata;
        seq_in.last    = s_tlast;
        seq_in.pre_len = '0;
        seq_in.tail    = TAIL_BYTE;
        prog_next      = prog_reg;
        done_next      = done_reg;
        if (done_reg) begin
            prog_next = 2'd0;
        end else if (s_tdata == pat1_byte(prog_reg)) begin
            if (prog_reg == 2'(PAT1_LEN - 1)) begin
                seq_in.tail = TAIL_REP;
                prog_next   = 2'd0;
                done_next   = 1'b1;
            end else begin
                prog_next   = prog_reg + 2'd1;
                seq_in.tail = TAIL_NONE;
                // At the end of the stream the held prefix is released at once.
                if (s_tlast) begin
                    seq_in.pre_len = SEQ_CNT_W'(prog_reg) + SEQ_CNT_W'(1);
                end
            end
        end else begin
            seq_in.pre_len = SEQ_CNT_W'(prog_reg);
            if (s_tdata == pat1_byte(2'd0)) begin
                prog_next   = 2'd1;
                seq_in.tail = s_tlast ? TAIL_BYTE : TAIL_NONE;
            end else begin
                prog_next = 2'd0;
            end
        end
        if (s_tlast) begin
            prog_next = 2'd0;
            done_next = 1'b0;
        end
    end

    assign len_in    = seq_len(seq_in, SEQ_CNT_W'(REP1_LEN));
    assign final_idx = (idx_reg == len_reg - SEQ_CNT_W'(1));
    assign last_beat = busy_reg && push_ready && final_idx;
    assign s_tready  = !busy_reg || last_beat;
    assign accept    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prog_reg <= 2'd0;
            done_reg <= 1'b0;
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            if (accept) begin
                prog_reg <= prog_next;
                done_reg <= done_next;
            end
            if (accept && (len_in != '0)) begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end else if (last_beat) begin
                busy_reg <= 1'b0;
            end else if (busy_reg && push_ready) begin
                idx_reg <= idx_reg + SEQ_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            seq_reg <= seq_in;
            len_reg <= len_in;
        end
    end

    always_comb begin
        if (idx_reg < seq_reg.pre_len) begin
            emit_byte = pat1_byte(idx_reg[1:0]);
        end else if (seq_reg.tail == TAIL_REP) begin
            emit_byte = rep1_byte(idx_reg);
        end else begin
            emit_byte = seq_reg.data;
        end
    end

    assign push_valid     = busy_reg;
    assign push_item.data = emit_byte;
    assign push_item.last = seq_reg.last && final_idx;

endmodule

`default_nettype wire

// File: rtl/tws_fifo.sv
// Short queue of bytes between the front and back matchers.
`timescale 1ns / 1ps
`default_nettype none

module tws_fifo import tws_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire tws_item_t wr_item,
    input  wire logic      wr_valid,
    output logic           wr_ready,
    output tws_item_t      rd_item,
    output logic           rd_valid,
    input  wire logic      rd_ready
);

    tws_item_t             entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] cnt_reg;
    logic                  do_wr;
    logic                  do_rd;

    assign wr_ready = (cnt_reg != FIFO_CNT_W'(FIFO_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;
    assign rd_item  = entry_reg[rd_ptr_reg];

    // The depth is a power of two, so the pointers simply wrap.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (do_rd) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            if (do_wr && !do_rd) begin
                cnt_reg <= cnt_reg + FIFO_CNT_W'(1);
            end else if (!do_wr && do_rd) begin
                cnt_reg <= cnt_reg - FIFO_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/tws_back.sv
// Back matcher: rewrites the first "nacas" in the queued stream and drives the output register.
`timescale 1ns / 1ps
`default_nettype none

module tws_back import tws_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire tws_item_t         pop_item,
    input  wire logic              pop_valid,
    output logic                   pop_ready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [BYTE_W-1:0]      m_tdata,
    output logic                   m_tlast
);

    logic [2:0]           prog_reg, prog_next;
    logic                 done_reg, done_next;
    logic                 busy_reg;
    logic [SEQ_CNT_W-1:0] idx_reg;
    logic [SEQ_CNT_W-1:0] len_reg;
    tws_seq_t             seq_reg;
    tws_seq_t             seq_in;
    logic [SEQ_CNT_W-1:0] len_in;
    logic                 accept;
    logic                 out_ready;
    logic                 final_idx;
    logic                 last_beat;
    logic [BYTE_W-1:0]    emit_byte;
    logic                 m_tvalid_reg;
    logic [BYTE_W-1:0]    m_tdata_reg;
    logic                 m_tlast_reg;

    always_comb begin
        seq_in.data    = pop_item.data;
        seq_in.last    = pop_item.last;
        seq_in.pre_len = '0;
        seq_in.tail    = TAIL_BYTE;
        prog_next      = prog_reg;
        done_next      = done_reg;
        if (done_reg) begin
            prog_next = 3'd0;
        end else if (pop_item.data == pat2_byte(prog_reg)) begin
            if (prog_reg == 3'(PAT2_LEN - 1)) begin
                seq_in.tail = TAIL_REP;
                prog_next   = 3'd0;
                done_next   = 1'b1;
            end else begin
                prog_next   = prog_reg + 3'd1;
                seq_in.tail = TAIL_NONE;
                if (pop_item.last) begin
                    seq_in.pre_len = SEQ_CNT_W'(prog_reg) + SEQ_CNT_W'(1);
                end
            end
        end else begin
            seq_in.pre_len = SEQ_CNT_W'(prog_reg);
            if (pop_item.data == pat2_byte(3'd0)) begin
                prog_next   = 3'd1;
                seq_in.tail = pop_item.last ? TAIL_BYTE : TAIL_NONE;
            end else begin
                prog_next = 3'd0;
            end
        end
        if (pop_item.last) begin
            prog_next = 3'd0;
            done_next = 1'b0;
        end
    end

    assign len_in    = seq_len(seq_in, SEQ_CNT_W'(REP2_LEN));
    assign out_ready = !m_tvalid_reg || m_tready;
    assign final_idx = (idx_reg == len_reg - SEQ_CNT_W'(1));
    assign last_beat = busy_reg && out_ready && final_idx;
    assign pop_ready = !busy_reg || last_beat;
    assign accept    = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prog_reg     <= 3'd0;
            done_reg     <= 1'b0;
            busy_reg     <= 1'b0;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                prog_reg <= prog_next;
                done_reg <= done_next;
            end
            if (accept && (len_in != '0)) begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end else if (last_beat) begin
                busy_reg <= 1'b0;
            end else if (busy_reg && out_ready) begin
                idx_reg <= idx_reg + SEQ_CNT_W'(1);
            end
            if (out_ready) begin
                m_tvalid_reg <= busy_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            seq_reg <= seq_in;
            len_reg <= len_in;
        end
        if (out_ready && busy_reg) begin
            m_tdata_reg <= emit_byte;
            m_tlast_reg <= seq_reg.last && final_idx;
        end
    end

    always_comb begin
        if (idx_reg < seq_reg.pre_len) begin
            emit_byte = pat2_byte(idx_reg[2:0]);
        end else if (seq_reg.tail == TAIL_REP) begin
            emit_byte = rep2_byte(idx_reg[2:0]);
        end else begin
            emit_byte = seq_reg.data;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

// File: rtl/two_word_stream_replacer_core.sv
// Path: input, front sequence register, queue entry, back sequence register, output register.
// Throughput: one byte per cycle when the output is not stalled; a replacement holds the input
// for its extra bytes, as the front matcher emits "wanaagsan" (nine bytes) and the back one
// "fariid" (six bytes), at one byte per cycle, while the queue absorbs the difference.
// Reset: synchronous, active low; clears both matchers, the queue and the output register,
// after which the next byte starts a new stream.
`timescale 1ns / 1ps
`default_nettype none

module two_word_stream_replacer_core import tws_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [BYTE_W-1:0] s_tdata,   // [7:0] in_byte
    input  wire logic              s_tlast,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [BYTE_W-1:0]      m_tdata,   // [7:0] out_byte
    output logic                   m_tlast
);

    tws_item_t q_wr_item;
    logic      q_wr_valid;
    logic      q_wr_ready;
    tws_item_t q_rd_item;
    logic      q_rd_valid;
    logic      q_rd_ready;

    tws_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push_item  (q_wr_item),
        .push_valid (q_wr_valid),
        .push_ready (q_wr_ready)
    );

    tws_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_item  (q_wr_item),
        .wr_valid (q_wr_valid),
        .wr_ready (q_wr_ready),
        .rd_item  (q_rd_item),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready)
    );

    tws_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_item  (q_rd_item),
        .pop_valid (q_rd_valid),
        .pop_ready (q_rd_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

// File: rtl/tws_checker.sv
// Port-level checks for the two-word stream replacer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module tws_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       s_tlast,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast
);

    logic [3:0] pend_reg;
    logic       s_end;
    logic       m_end;

    assign s_end = s_tvalid && s_tready && s_tlast;
    assign m_end = m_tvalid && m_tready && m_tlast;

    // Streams whose final input transfer has been taken but whose final output has not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 4'd0;
        end else if (s_end && !m_end) begin
            pend_reg <= pend_reg + 4'd1;
        end else if (!s_end && m_end) begin
            pend_reg <= pend_reg - 4'd1;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("output transfer changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && s_tready))
        else $error("block not idle after reset");

    a_end_follows_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_end |-> (pend_reg != 4'd0))
        else $error("stream end emitted without a matching input end");

    a_end_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg <= 4'd9)
        else $error("too many unfinished streams in flight");

endmodule

bind two_word_stream_replacer_core tws_checker u_tws_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
